// File: rtl/core/b32cd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32cd_pkg
// Shared types and constants of the base-32 check digit code decoder.
// ----------------------------------------------------------------------------
package b32cd_pkg;

  localparam int MAX_KEPT = 31;
  localparam int KEPT_W   = $clog2(MAX_KEPT + 1);
  localparam int HIST_W   = 55;

  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic [5:0] FIXED_INIT  = 6'd36;
  localparam logic [5:0] LEGACY_INIT = 6'd36;

  localparam logic [KEPT_W-1:0] LEN_OLD11 = KEPT_W'(11);
  localparam logic [KEPT_W-1:0] LEN_CUR12 = KEPT_W'(12);
  localparam logic [KEPT_W-1:0] LEN_OLD14 = KEPT_W'(14);
  localparam logic [KEPT_W-1:0] LEN_OLD18 = KEPT_W'(18);

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_MALFORMED = 2'd1,
    STATUS_OLD       = 2'd2,
    STATUS_FUTURE    = 2'd3
  } status_t;

  // classified character, front to back
  typedef struct packed {
    logic       last;
    logic       skip;
    logic       norm_bad;
    logic [5:0] norm_v;
    logic       crock_bad;
    logic [4:0] crock_g;
    logic       lit_bad;
    logic [5:0] lit_v;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] ip_address;
    logic [15:0] port;
  } result_t;

endpackage

// File: rtl/core/b32cd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32cd_front
// Classifies one raw character: skip, base-36 and Crockford values.
// ----------------------------------------------------------------------------
module b32cd_front import b32cd_pkg::*; (
  input  logic [7:0] char_byte,
  input  logic       last_char,
  output item_t      item
);

  function automatic logic [6:0] b36_of(input logic [7:0] c);
    logic [6:0] r;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 6'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      r = {1'b0, 6'(c - 8'h41 + 8'd10)};
    end else begin
      r = {1'b1, 6'd0};
    end
    return r;
  endfunction

  function automatic logic [5:0] crock_of(input logic [7:0] c);
    logic [5:0] r;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 5'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h48) begin
      r = {1'b0, 5'(c - 8'h41 + 8'd10)};
    end else if (c == 8'h4A) begin
      r = {1'b0, 5'd18};
    end else if (c == 8'h4B) begin
      r = {1'b0, 5'd19};
    end else if (c == 8'h4D) begin
      r = {1'b0, 5'd20};
    end else if (c == 8'h4E) begin
      r = {1'b0, 5'd21};
    end else if (c >= 8'h50 && c <= 8'h54) begin
      r = {1'b0, 5'(c - 8'h50 + 8'd22)};
    end else if (c >= 8'h56 && c <= 8'h5A) begin
      r = {1'b0, 5'(c - 8'h56 + 8'd27)};
    end else begin
      r = {1'b1, 5'd0};
    end
    return r;
  endfunction

  logic [7:0] upper;
  logic [7:0] norm;
  logic [6:0] norm_b36;
  logic [6:0] lit_b36;
  logic [5:0] crock;

  always_comb begin
    upper = char_byte;
    if (char_byte >= 8'h61 && char_byte <= 8'h7A) begin
      upper = char_byte - 8'h20;
    end
    norm = upper;
    if (upper == 8'h49 || upper == 8'h4C) begin
      norm = 8'h31;
    end else if (upper == 8'h4F) begin
      norm = 8'h30;
    end
    norm_b36 = b36_of(norm);
    lit_b36  = b36_of(upper);
    crock    = crock_of(norm);

    item.last      = last_char;
    item.skip      = (char_byte == 8'h2D) || (char_byte == 8'h20) || (char_byte == 8'h09) ||
                     (char_byte == 8'h0D) || (char_byte == 8'h0A);
    item.norm_bad  = norm_b36[6];
    item.norm_v    = norm_b36[5:0];
    item.crock_bad = crock[5];
    item.crock_g   = crock[4:0];
    item.lit_bad   = lit_b36[6];
    item.lit_v     = lit_b36[5:0];
  end

endmodule

// File: rtl/core/b32cd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32cd_queue
// Short queue of classified characters between front and back.
// ----------------------------------------------------------------------------
module b32cd_queue import b32cd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_en,
  input  item_t wr_item,
  output logic  full,
  input  logic  rd_en,
  output logic  rd_valid,
  output item_t rd_item
);

  item_t             entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_wr;
  logic              do_rd;

  assign full     = (count == QCNT_W'(QDEPTH));
  assign rd_valid = (count != '0);
  assign rd_item  = entries[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_item;
    end
  end

endmodule

// File: rtl/core/b32cd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32cd_back
// Runs the MOD 37,36 recurrence and a legacy variant that adds modulo 37, tracks the code and dispatches on length.
// ----------------------------------------------------------------------------
module b32cd_back import b32cd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  item_t   in_item,
  output logic    in_take,
  output logic    res_valid,
  output result_t res,
  input  logic    res_take
);

  function automatic logic [5:0] fixed_step(input logic [5:0] p, input logic [5:0] v);
    logic [6:0] sum;
    logic [6:0] dbl;
    sum = {1'b0, p} + {1'b0, v};
    if (sum >= 7'd36) begin
      sum = sum - 7'd36;
    end
    if (sum == 7'd0) begin
      sum = 7'd36;
    end
    dbl = {sum[5:0], 1'b0};
    if (dbl >= 7'd37) begin
      dbl = dbl - 7'd37;
    end
    return dbl[5:0];
  endfunction

  function automatic logic [5:0] legacy_step(input logic [5:0] p, input logic [5:0] v);
    logic [6:0] sum;
    logic [6:0] dbl;
    sum = {1'b0, p} + {1'b0, v};
    if (sum >= 7'd37) begin
      sum = sum - 7'd37;
    end
    if (sum == 7'd0) begin
      sum = 7'd37;
    end
    dbl = {sum[5:0], 1'b0};
    if (dbl >= 7'd74) begin
      dbl = dbl - 7'd74;
    end else if (dbl >= 7'd37) begin
      dbl = dbl - 7'd37;
    end
    return dbl[5:0];
  endfunction

  function automatic logic check_ok(input logic [5:0] p, input logic bad_before,
                                    input logic lit_bad, input logic [5:0] lit_v);
    logic [6:0] t;
    t = 7'd37 - {1'b0, p};
    if (t >= 7'd36) begin
      t = t - 7'd36;
    end
    return !bad_before && !lit_bad && (t[5:0] == lit_v);
  endfunction

  logic [KEPT_W-1:0] kept_count, kept_count_next;
  logic [5:0]        fixed_product, fixed_product_next;
  logic [5:0]        legacy_product, legacy_product_next;
  logic [5:0]        fixed_before, fixed_before_next;
  logic [5:0]        legacy_before, legacy_before_next;
  logic              bad_before, bad_before_next;
  logic              bad_latest, bad_latest_next;
  logic [5:0]        first_v, first_v_next;
  logic              first_ok, first_ok_next;
  logic              crock_middle, crock_middle_next;
  logic              crock_latest, crock_latest_next;
  logic [5:0]        lit_v, lit_v_next;
  logic              lit_bad, lit_bad_next;
  logic [HIST_W-1:0] history, history_next;

  logic    kept;
  logic    fixed_ok;
  logic    legacy_ok;
  logic    finish;
  result_t res_next;

  assign in_take = in_valid && (!in_item.last || !res_valid || res_take);
  assign finish  = in_take && in_item.last;
  assign kept    = !in_item.skip && (kept_count < KEPT_W'(MAX_KEPT));

  always_comb begin
    kept_count_next     = kept_count;
    fixed_product_next  = fixed_product;
    legacy_product_next = legacy_product;
    fixed_before_next   = fixed_before;
    legacy_before_next  = legacy_before;
    bad_before_next     = bad_before;
    bad_latest_next     = bad_latest;
    first_v_next        = first_v;
    first_ok_next       = first_ok;
    crock_middle_next   = crock_middle;
    crock_latest_next   = crock_latest;
    lit_v_next          = lit_v;
    lit_bad_next        = lit_bad;
    history_next        = history;
    if (kept) begin
      fixed_before_next  = fixed_product;
      legacy_before_next = legacy_product;
      bad_before_next    = bad_latest;
      if (in_item.norm_bad) begin
        bad_latest_next = 1'b1;
      end else begin
        fixed_product_next  = fixed_step(fixed_product, in_item.norm_v);
        legacy_product_next = legacy_step(legacy_product, in_item.norm_v);
      end
      if (kept_count >= KEPT_W'(2)) begin
        crock_middle_next = crock_middle || crock_latest;
      end
      crock_latest_next = in_item.crock_bad;
      history_next      = {history[HIST_W-6:0], in_item.crock_g};
      if (kept_count == '0) begin
        first_v_next  = in_item.norm_v;
        first_ok_next = !in_item.norm_bad;
      end
      lit_v_next      = in_item.lit_v;
      lit_bad_next    = in_item.lit_bad;
      kept_count_next = kept_count + 1'b1;
    end
  end

  // length dispatch on the state after this character
  always_comb begin
    fixed_ok  = check_ok(fixed_before_next, bad_before_next, lit_bad_next, lit_v_next);
    legacy_ok = check_ok(legacy_before_next, bad_before_next, lit_bad_next, lit_v_next);
    res_next.status     = STATUS_MALFORMED;
    res_next.ip_address = '0;
    res_next.port       = '0;
    if (kept_count_next == LEN_OLD11) begin
      if (legacy_ok && first_ok_next && first_v_next < 6'd8 && !crock_middle_next) begin
        res_next.status = STATUS_OLD;
      end
    end else if (kept_count_next == LEN_OLD14) begin
      if (first_ok_next && first_v_next == 6'd2 && legacy_ok && !crock_middle_next) begin
        res_next.status = STATUS_OLD;
      end
    end else if (kept_count_next == LEN_OLD18) begin
      if (first_ok_next && first_v_next == 6'd3 && fixed_ok && !crock_middle_next) begin
        res_next.status = STATUS_OLD;
      end
    end else if (kept_count_next == LEN_CUR12) begin
      if (!(first_ok_next && first_v_next == 6'd4)) begin
        res_next.status = STATUS_FUTURE;
      end else if (fixed_ok && !crock_middle_next) begin
        res_next.status     = STATUS_OK;
        res_next.ip_address = history_next[54:23];
        res_next.port       = history_next[22:7];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || finish) begin
      kept_count     <= '0;
      fixed_product  <= FIXED_INIT;
      legacy_product <= LEGACY_INIT;
      fixed_before   <= FIXED_INIT;
      legacy_before  <= LEGACY_INIT;
      bad_before     <= 1'b0;
      bad_latest     <= 1'b0;
      first_v        <= '0;
      first_ok       <= 1'b0;
      crock_middle   <= 1'b0;
      crock_latest   <= 1'b0;
      lit_v          <= '0;
      lit_bad        <= 1'b1;
      history        <= '0;
    end else if (in_take) begin
      kept_count     <= kept_count_next;
      fixed_product  <= fixed_product_next;
      legacy_product <= legacy_product_next;
      fixed_before   <= fixed_before_next;
      legacy_before  <= legacy_before_next;
      bad_before     <= bad_before_next;
      bad_latest     <= bad_latest_next;
      first_v        <= first_v_next;
      first_ok       <= first_ok_next;
      crock_middle   <= crock_middle_next;
      crock_latest   <= crock_latest_next;
      lit_v          <= lit_v_next;
      lit_bad        <= lit_bad_next;
      history        <= history_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (finish) begin
      res_valid <= 1'b1;
    end else if (res_take) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      res <= res_next;
    end
  end

endmodule

// File: rtl/core/base32_check_digit_code_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base32_check_digit_code_decoder
// Crockford base-32 code decoder with ISO 7064 MOD 37,36 check character.
// ----------------------------------------------------------------------------
// Takes one text byte per cycle while the queue is not full and returns one
// result per code. A code's last byte passes through the queue and then the
// back end's output register before its result is ready to pop. The front
// classifies each byte combinationally into a four-entry queue; the back end
// updates both check recurrences for one queued byte per cycle and holds the
// result in a single output register, so it only stalls on a code's last
// byte while the previous result has not been popped. Status: 0 ok (IPv4
// address and port valid), 1 malformed, 2 old format, 3 future version.
module base32_check_digit_code_decoder import b32cd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  char_byte,
  input  logic        last_char,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status,
  output logic [31:0] ip_address,
  output logic [15:0] port
);

  item_t   front_item;
  item_t   q_item;
  logic    q_valid;
  logic    q_take;
  logic    res_valid;
  result_t res;

  b32cd_front u_front (
    .char_byte (char_byte),
    .last_char (last_char),
    .item      (front_item)
  );

  b32cd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (push),
    .wr_item  (front_item),
    .full     (full),
    .rd_en    (q_take),
    .rd_valid (q_valid),
    .rd_item  (q_item)
  );

  b32cd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_item   (q_item),
    .in_take   (q_take),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (pop)
  );

  assign empty      = !res_valid;
  assign status     = res.status;
  assign ip_address = res.ip_address;
  assign port       = res.port;

endmodule

// File: dv/base32_check_digit_code_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base32_check_digit_code_decoder_tb
// Self-checking bench for the base-32 check digit code decoder. Code texts go
// in one byte per transfer: a directed table first (empty, overlong, every
// length format, bad characters, wrong checks), then random codes, mostly
// with a valid check character, in mixed case, with aliases and separators,
// and some noise. Each result is compared with a behavioral decoder, or with
// a typed table status, under several sender and receiver idle patterns.
// ----------------------------------------------------------------------------
module base32_check_digit_code_decoder_tb;
  import b32cd_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 5;
  localparam int ITEM_TARGET    = 1000;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int CROCK_INVALID  = 32;
  localparam int OLD11_TOP_MASK = 'h18;
  localparam int CHECK_MOD      = 36;
  localparam int LEGACY_MOD     = 37;
  localparam int N_DIRECTED     = 17;
  localparam int N_PHASES       = 4;

  localparam string CROCK_ALPHABET = "0123456789ABCDEFGHJKMNPQRSTVWXYZ";
  localparam string SKIP_CHARS     = "- \t\r\n";
  localparam string ALIAS_ONE      = "IiLl";
  localparam string ALIAS_ZERO     = "Oo";

  typedef struct {
    int                kept;
    int                fixed_prod;
    int                legacy_prod;
    int                fixed_prod_prev;
    int                legacy_prod_prev;
    bit                alnum_bad_prev;
    bit                alnum_bad;
    logic [7:0]        first_char;
    bit                crock_bad_mid;
    bit                crock_bad_last;
    logic [7:0]        check_lit;
    logic [HIST_W-1:0] groups;
  } code_state_t;

  // a '?' in the text stands for the correct check character
  typedef struct {
    string   text;
    bit      typed;
    status_t status;
  } code_row_t;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        push       = 1'b0;
  logic [7:0]  char_byte  = 8'h00;
  logic        last_char  = 1'b0;
  logic        pop        = 1'b0;
  logic        full;
  logic        empty;
  logic [1:0]  status;
  logic [31:0] ip_address;
  logic [15:0] port;

  code_state_t dec_state;
  result_t     pending_results [$];
  logic [7:0]  code_bytes [$];
  bit          typed_valid    = 1'b0;
  status_t     typed_status   = STATUS_MALFORMED;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          bytes_pushed   = 0;
  int          codes_pushed   = 0;
  int          results_seen   = 0;
  int          status_seen [4];
  int          error_count    = 0;
  int          cycle_count    = 0;

  int idle_plan  [N_PHASES] = '{0, 82, 0, 21};
  int stall_plan [N_PHASES] = '{0, 0, 82, 21};

  code_row_t directed [N_DIRECTED] = '{
    '{"-",                                 1'b1, STATUS_MALFORMED},
    '{"\001",                              1'b1, STATUS_MALFORMED},
    '{"\377",                              1'b1, STATUS_MALFORMED},
    '{"5ABCDEFGHJK1",                      1'b1, STATUS_FUTURE},
    '{"ABCDEFGHJKMNP",                     1'b1, STATUS_MALFORMED},
    '{"0123456789ABCDEFGHJKMNPQRSTVWXYZ0", 1'b1, STATUS_MALFORMED},
    '{"4ZZZZZZZZZZ?",                      1'b0, STATUS_OK},
    '{"40000000000?",                      1'b0, STATUS_OK},
    '{"4-iLoO 12ab\tcd?",                  1'b0, STATUS_OK},
    '{"\r\n -4zzzzzzzzzz?\t-",             1'b0, STATUS_OK},
    '{"7zzzzzzzzz?",                       1'b0, STATUS_OK},
    '{"2ABCDEFGHJKMN?",                    1'b0, STATUS_OK},
    '{"3ABCDEFGHJKMNPQRS?",                1'b0, STATUS_OK},
    '{"8ABCDEFGHJ?",                       1'b0, STATUS_OK},
    '{"4000U000000?",                      1'b0, STATUS_OK},
    '{"4000#000000?",                      1'b0, STATUS_OK},
    '{"40000000000Z",                      1'b0, STATUS_OK}
  };

  base32_check_digit_code_decoder u_top (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .char_byte  (char_byte),
    .last_char  (last_char),
    .empty      (empty),
    .pop        (pop),
    .status     (status),
    .ip_address (ip_address),
    .port       (port)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic bit is_skip(logic [7:0] c);
    return c == "-" || c == " " || c == "\t" || c == "\r" || c == "\n";
  endfunction

  function automatic int crock_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "A" && c <= "H") return 10 + (c - "A");
    if (c == "J") return 18;
    if (c == "K") return 19;
    if (c == "M") return 20;
    if (c == "N") return 21;
    if (c >= "P" && c <= "T") return 22 + (c - "P");
    if (c >= "V" && c <= "Z") return 27 + (c - "V");
    return CROCK_INVALID;
  endfunction

  function automatic int alnum_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "A" && c <= "Z") return 10 + (c - "A");
    return -1;
  endfunction

  function automatic code_state_t fresh_state();
    code_state_t s;
    s.kept             = 0;
    s.fixed_prod       = FIXED_INIT;
    s.legacy_prod      = LEGACY_INIT;
    s.fixed_prod_prev  = FIXED_INIT;
    s.legacy_prod_prev = LEGACY_INIT;
    s.alnum_bad_prev   = 1'b0;
    s.alnum_bad        = 1'b0;
    s.first_char       = 8'h00;
    s.crock_bad_mid    = 1'b0;
    s.crock_bad_last   = 1'b0;
    s.check_lit        = 8'h00;
    s.groups           = '0;
    return s;
  endfunction

  function automatic code_state_t absorb_byte(code_state_t s, logic [7:0] raw);
    logic [7:0] up;
    logic [7:0] norm;
    int         v;
    int         g;
    int         t;
    if (is_skip(raw) || s.kept >= MAX_KEPT) return s;
    up   = (raw >= "a" && raw <= "z") ? raw - 8'h20 : raw;
    norm = (up == "I" || up == "L") ? "1" : (up == "O") ? "0" : up;
    s.fixed_prod_prev  = s.fixed_prod;
    s.legacy_prod_prev = s.legacy_prod;
    s.alnum_bad_prev   = s.alnum_bad;
    v = alnum_value(norm);
    if (v < 0) begin
      s.alnum_bad = 1'b1;
    end else begin
      t = (s.fixed_prod + v) % CHECK_MOD;
      if (t == 0) t = CHECK_MOD;
      s.fixed_prod = (2 * t) % LEGACY_MOD;
      t = (s.legacy_prod + v) % LEGACY_MOD;
      if (t == 0) t = LEGACY_MOD;
      s.legacy_prod = (2 * t) % LEGACY_MOD;
    end
    g = crock_value(norm);
    if (s.kept >= 2) s.crock_bad_mid = s.crock_bad_mid | s.crock_bad_last;
    s.crock_bad_last = (g == CROCK_INVALID);
    s.groups = {s.groups[HIST_W-6:0], g[4:0]};
    if (s.kept == 0) s.first_char = norm;
    s.check_lit = up;
    s.kept++;
    return s;
  endfunction

  function automatic bit check_holds(code_state_t s, int prod);
    int lit_v;
    lit_v = alnum_value(s.check_lit);
    if (s.alnum_bad_prev || lit_v < 0) return 1'b0;
    return ((LEGACY_MOD - prod) % CHECK_MOD) == lit_v;
  endfunction

  function automatic result_t decode_code(code_state_t s);
    result_t     r;
    int          top;
    logic [49:0] payload;
    r       = '{STATUS_MALFORMED, 32'h0, 16'h0};
    top     = crock_value(s.first_char);
    payload = s.groups[HIST_W-1:5];
    case (s.kept)
      LEN_OLD11: begin
        if (check_holds(s, s.legacy_prod_prev) && top != CROCK_INVALID &&
            (top & OLD11_TOP_MASK) == 0 && !s.crock_bad_mid)
          r.status = STATUS_OLD;
      end
      LEN_OLD14: begin
        if (s.first_char == "2" && check_holds(s, s.legacy_prod_prev) && !s.crock_bad_mid)
          r.status = STATUS_OLD;
      end
      LEN_OLD18: begin
        if (s.first_char == "3" && check_holds(s, s.fixed_prod_prev) && !s.crock_bad_mid)
          r.status = STATUS_OLD;
      end
      LEN_CUR12: begin
        if (s.first_char != "4") begin
          r.status = STATUS_FUTURE;
        end else if (check_holds(s, s.fixed_prod_prev) && !s.crock_bad_mid) begin
          r.status     = STATUS_OK;
          r.ip_address = payload[49:18];
          r.port       = payload[17:2];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // check character that makes the code valid if it is kept next
  function automatic logic [7:0] check_char(code_state_t s);
    int prod;
    int v;
    prod = (s.kept + 1 == LEN_OLD11 || s.kept + 1 == LEN_OLD14) ? s.legacy_prod : s.fixed_prod;
    v = (LEGACY_MOD - prod) % CHECK_MOD;
    return (v < 10) ? 8'("0" + v) : 8'("A" + v - 10);
  endfunction

  function automatic logic [7:0] random_code_char();
    logic [7:0] c;
    c = CROCK_ALPHABET[$urandom_range(31)];
    if (c == "1" && $urandom_range(3) == 0) return ALIAS_ONE[$urandom_range(3)];
    if (c == "0" && $urandom_range(3) == 0) return ALIAS_ZERO[$urandom_range(1)];
    if (c >= "A" && $urandom_range(1) == 0) return c + 8'h20;
    return c;
  endfunction

  task automatic flag_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic send_byte(logic [7:0] b, logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push      <= 1'b1;
    char_byte <= b;
    last_char <= is_last;
    @(posedge clk);
    while (full) @(posedge clk);
    bytes_pushed++;
    @(negedge clk);
  endtask

  task automatic send_code(bit typed, status_t st);
    typed_valid  = typed;
    typed_status = st;
    for (int i = 0; i < code_bytes.size(); i++)
      send_byte(code_bytes[i], i == code_bytes.size() - 1);
    codes_pushed++;
  endtask

  task automatic load_directed(string text);
    code_state_t s;
    logic [7:0]  c;
    s = fresh_state();
    code_bytes.delete();
    for (int i = 0; i < text.len(); i++) begin
      c = text[i];
      if (c == "?") c = check_char(s);
      s = absorb_byte(s, c);
      code_bytes.push_back(c);
    end
  endtask

  task automatic load_random();
    logic [7:0]  chars [$];
    logic [7:0]  c;
    code_state_t s;
    int          kind;
    int          len;
    int          fix_at;
    int          pick;
    kind = $urandom_range(9);
    case (kind)
      4:       len = 11;
      5:       len = 14;
      6:       len = 18;
      8:       len = $urandom_range(1, 20);
      9:       len = $urandom_range(1, 34);
      default: len = 12;
    endcase
    for (int i = 0; i < len; i++) chars.push_back(random_code_char());
    case (kind)
      0, 1, 2, 3: chars[0] = "4";
      4:          chars[0] = 8'("0" + $urandom_range(7));
      5:          chars[0] = "2";
      6:          chars[0] = "3";
      7:          if (chars[0] == "4") chars[0] = "5";
      8:          foreach (chars[i]) chars[i] = 8'($urandom_range(1, 255));
      default: ;
    endcase
    fix_at = (kind == 8) ? -1 : len - 1;
    if ($urandom_range(99) < 15) begin
      pick = $urandom_range(len - 1);
      chars[pick] = 8'($urandom_range(1, 255));
      if (pick == fix_at) fix_at = -1;
    end
    s = fresh_state();
    code_bytes.delete();
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 8) code_bytes.push_back(SKIP_CHARS[$urandom_range(4)]);
      c = chars[i];
      if (i == fix_at) begin
        c = check_char(s);
        if (c >= "A" && $urandom_range(1) == 0) c = c + 8'h20;
      end
      s = absorb_byte(s, c);
      code_bytes.push_back(c);
    end
    if ($urandom_range(99) < 10) code_bytes.push_back(SKIP_CHARS[$urandom_range(4)]);
  endtask

  always @(negedge clk) begin
    pop <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst) begin
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          flag_mismatch($sformatf("result with no code pending, status %0d", status));
        end else begin
          want = pending_results.pop_front();
          if (status !== want.status)
            flag_mismatch($sformatf("status %0d, want %0d", status, want.status));
          if (ip_address !== want.ip_address)
            flag_mismatch($sformatf("ip_address %h, want %h", ip_address, want.ip_address));
          if (port !== want.port)
            flag_mismatch($sformatf("port %h, want %h", port, want.port));
          results_seen++;
          status_seen[want.status]++;
        end
      end
      if (push && !full) begin
        dec_state = absorb_byte(dec_state, char_byte);
        if (last_char) begin
          want = decode_code(dec_state);
          if (typed_valid) want = '{typed_status, 32'h0, 16'h0};
          pending_results.push_back(want);
          dec_state = fresh_state();
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("base32_check_digit_code_decoder test failed");
      $finish;
    end
  end

  initial begin
    int base;
    dec_state = fresh_state();
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed[i]) begin
      load_directed(directed[i].text);
      send_code(directed[i].typed, directed[i].status);
    end

    // hold until every result is back
    push <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);

    base = bytes_pushed;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      send_idle_pct  = idle_plan[ph];
      recv_stall_pct = stall_plan[ph];
      while (bytes_pushed < base + (ph + 1) * ITEM_TARGET / N_PHASES) begin
        load_random();
        send_code(1'b0, STATUS_MALFORMED);
      end
    end

    push <= 1'b0;
    recv_stall_pct = 0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("ran %0d codes (%0d bytes) under four idle patterns, %0d results compared",
             codes_pushed, bytes_pushed, results_seen);
    $display("by status: %0d ok, %0d malformed, %0d old format, %0d future version",
             status_seen[STATUS_OK], status_seen[STATUS_MALFORMED],
             status_seen[STATUS_OLD], status_seen[STATUS_FUTURE]);
    if (error_count == 0) begin
      $display("base32_check_digit_code_decoder test passed");
    end else begin
      $display("base32_check_digit_code_decoder test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/b32cd_pkg.sv
rtl/core/b32cd_front.sv
rtl/core/b32cd_queue.sv
rtl/core/b32cd_back.sv
rtl/core/base32_check_digit_code_decoder.sv
dv/base32_check_digit_code_decoder_tb.sv
